/* hw/rtl/ctd_pkg.sv */
// ----------------------------------------------------------------------------
// ctd_pkg
// Shared types, codes and constants of the charge termination detector.
// ----------------------------------------------------------------------------
package ctd_pkg;

    localparam int SLOPE_SLOTS_DEF = 6;

    localparam int VOLT_W  = 13;
    localparam int MIN_W   = 10;
    localparam int CFG_W   = 13;
    localparam int INDEX_W = 2;

    localparam int TICK_MS          = 200;
    localparam int CHARGE_OFFSET_MV = 20;
    localparam int OV_DEBOUNCE      = 3;
    localparam int OV_RUN_MAX       = 3;
    localparam int PIN_DEBOUNCE     = 6;
    localparam int PIN_RUN_MAX      = 7;
    localparam int OV_MEASURE       = (2 * 1000) / TICK_MS;
    localparam int PIN_MEASURE      = (2 * 1000) / TICK_MS;
    localparam int SLOPE_MEASURE    = (20 * 1000) / TICK_MS;
    localparam int PHASE_WRAP       = SLOPE_MEASURE;
    localparam int PHASE_W          = $clog2(PHASE_WRAP);
    localparam int OV_RUN_W         = $clog2(OV_RUN_MAX + 1);
    localparam int PIN_RUN_W        = $clog2(PIN_RUN_MAX + 1);

    localparam int TIMEOUT_RESET  = 90;
    localparam int FULL_MV_RESET  = 4200;
    localparam int PIN_PRES_RESET = 1;

    typedef logic [2:0] reason_t;
    localparam reason_t REASON_NONE    = 3'd0;
    localparam reason_t REASON_TIMEOUT = 3'd1;
    localparam reason_t REASON_OVERVOLT = 3'd2;
    localparam reason_t REASON_PIN     = 3'd3;
    localparam reason_t REASON_SLOPE   = 3'd4;

    typedef logic [INDEX_W-1:0] cfg_index_t;
    localparam cfg_index_t CFG_TIMEOUT  = 2'd0;
    localparam cfg_index_t CFG_FULL_MV  = 2'd1;
    localparam cfg_index_t CFG_PIN_PRES = 2'd2;

    typedef struct packed {
        logic [MIN_W-1:0]  timeout_min;
        logic [VOLT_W-1:0] full_mv;
        logic              pin_present;
    } cfg_t;

    typedef logic [PHASE_W-1:0] phase_t;

    // phase values at which the overvoltage stage samples
    function automatic logic ov_phase_hit(input phase_t p);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < PHASE_WRAP / OV_MEASURE; k++)
        begin
            if (p == PHASE_W'(k * OV_MEASURE))
                hit = 1'b1;
        end
        return hit;
    endfunction

    function automatic logic pin_phase_hit(input phase_t p);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < PHASE_WRAP / PIN_MEASURE; k++)
        begin
            if (p == PHASE_W'(k * PIN_MEASURE))
                hit = 1'b1;
        end
        return hit;
    endfunction

    function automatic phase_t phase_inc(input phase_t p);
        return (p == PHASE_W'(PHASE_WRAP - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

/* hw/rtl/ctd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// ctd_cfg_regs
// Configuration registers: timeout, full voltage and pin-present flag.
// ----------------------------------------------------------------------------
module ctd_cfg_regs
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  ctd_pkg::cfg_index_t cfg_index,
    input  logic [ctd_pkg::CFG_W-1:0] cfg_data,
    output ctd_pkg::cfg_t       cfg
);

    ctd_pkg::cfg_t cfg_reg;
    ctd_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                ctd_pkg::CFG_TIMEOUT:
                    cfg_next.timeout_min = cfg_data[ctd_pkg::MIN_W-1:0];
                ctd_pkg::CFG_FULL_MV:
                    cfg_next.full_mv = cfg_data[ctd_pkg::VOLT_W-1:0];
                ctd_pkg::CFG_PIN_PRES:
                    cfg_next.pin_present = cfg_data[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_min <= ctd_pkg::MIN_W'(ctd_pkg::TIMEOUT_RESET);
            cfg_reg.full_mv     <= ctd_pkg::VOLT_W'(ctd_pkg::FULL_MV_RESET);
            cfg_reg.pin_present <= 1'(ctd_pkg::PIN_PRES_RESET);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hw/rtl/ctd_decide.sv */
// ----------------------------------------------------------------------------
// ctd_decide
// Check stages and their state: timeout, overvoltage and pin debounce,
// slope sign ring. State moves once per item taken.
// ----------------------------------------------------------------------------
module ctd_decide
#(
    parameter int SLOPE_SLOTS = ctd_pkg::SLOPE_SLOTS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic [ctd_pkg::VOLT_W-1:0] voltage_mv,
    input  logic [ctd_pkg::MIN_W-1:0]  elapsed_minutes,
    input  logic                       ext_pin_level,
    input  ctd_pkg::cfg_t              cfg,
    output ctd_pkg::reason_t           reason
);

    localparam int SLOT_W   = $clog2(SLOPE_SLOTS);
    localparam int CNT_W    = $clog2(SLOPE_SLOTS + 1);
    localparam int FLAT_MAX = (SLOPE_SLOTS + 1) / 2;
    localparam int VW1      = ctd_pkg::VOLT_W + 1;

    ctd_pkg::phase_t               phase_reg, phase_next;
    logic [ctd_pkg::OV_RUN_W-1:0]  ov_run_reg, ov_run_next;
    logic [ctd_pkg::PIN_RUN_W-1:0] pin_run_reg, pin_run_next;
    logic [ctd_pkg::VOLT_W-1:0]    prev_reg, prev_next;
    logic [SLOPE_SLOTS-1:0]        ring_reg, ring_next;
    logic [SLOT_W-1:0]             slot_reg, slot_next;

    ctd_pkg::phase_t p1, p2, p3;
    logic            timeout, ov_hit, ov_full, pin_hit, pin_full, slope_hit;
    logic            ov_high, near_full, flat;
    logic [CNT_W-1:0] pos_count;

    always_comb
    begin
        ov_run_next  = ov_run_reg;
        pin_run_next = pin_run_reg;
        prev_next    = prev_reg;
        ring_next    = ring_reg;
        slot_next    = slot_reg;
        phase_next   = phase_reg;
        reason       = ctd_pkg::REASON_NONE;
        ov_full      = 1'b0;
        pin_full     = 1'b0;
        pos_count    = '0;
        flat         = 1'b0;

        timeout   = elapsed_minutes >= cfg.timeout_min;
        ov_hit    = ctd_pkg::ov_phase_hit(phase_reg);
        p1        = ctd_pkg::phase_inc(phase_reg);
        pin_hit   = ctd_pkg::pin_phase_hit(p1);
        p2        = ctd_pkg::phase_inc(p1);
        // slope period equals the phase wrap
        slope_hit = (p2 == '0);
        p3        = ctd_pkg::phase_inc(p2);

        ov_high   = {1'b0, voltage_mv} >= ({1'b0, cfg.full_mv}
                    + VW1'(ctd_pkg::CHARGE_OFFSET_MV));
        // voltage >= full - offset, computed unsigned as voltage + offset >= full
        near_full = ({1'b0, voltage_mv} + VW1'(ctd_pkg::CHARGE_OFFSET_MV))
                    >= {1'b0, cfg.full_mv};

        if (timeout)
        begin
            reason = ctd_pkg::REASON_TIMEOUT;
        end
        else
        begin
            phase_next = p1;
            if (ov_hit)
            begin
                if (!ov_high)
                    ov_run_next = '0;
                else if (ov_run_reg < ctd_pkg::OV_RUN_W'(ctd_pkg::OV_RUN_MAX))
                    ov_run_next = ov_run_reg + 1'b1;
                ov_full = ov_run_next >= ctd_pkg::OV_RUN_W'(ctd_pkg::OV_DEBOUNCE);
            end

            if (ov_full)
            begin
                reason = ctd_pkg::REASON_OVERVOLT;
            end
            else
            begin
                phase_next = p2;
                if (pin_hit && cfg.pin_present)
                begin
                    if (!ext_pin_level)
                        pin_run_next = '0;
                    else if (pin_run_reg < ctd_pkg::PIN_RUN_W'(ctd_pkg::PIN_RUN_MAX))
                        pin_run_next = pin_run_reg + 1'b1;
                    pin_full = pin_run_next >=
                               ctd_pkg::PIN_RUN_W'(ctd_pkg::PIN_DEBOUNCE);
                end

                if (pin_full)
                begin
                    reason = ctd_pkg::REASON_PIN;
                end
                else
                begin
                    phase_next = p3;
                    if (slope_hit)
                    begin
                        prev_next = voltage_mv;
                        slot_next = (slot_reg == SLOT_W'(SLOPE_SLOTS - 1)) ?
                                    '0 : slot_reg + 1'b1;
                        if (prev_reg == '0)
                        begin
                            // no reference yet
                            ring_next = '1;
                        end
                        else
                        begin
                            ring_next[slot_reg] = voltage_mv > prev_reg;
                            pos_count = CNT_W'($countones(ring_next));
                            flat = pos_count <= CNT_W'(FLAT_MAX);
                            if (flat && near_full)
                                reason = ctd_pkg::REASON_SLOPE;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= '0;
            ov_run_reg  <= '0;
            pin_run_reg <= '0;
            prev_reg    <= '0;
            ring_reg    <= '1;
            slot_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            ov_run_reg  <= ov_run_next;
            pin_run_reg <= pin_run_next;
            prev_reg    <= prev_next;
            ring_reg    <= ring_next;
            slot_reg    <= slot_next;
        end
    end

endmodule

/* hw/rtl/charge_termination_detector.sv */
// ----------------------------------------------------------------------------
// charge_termination_detector
// Judges end of charge per tick and gives the reason.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one tick: voltage_mv,
//   elapsed_minutes, ext_pin_level. Output channel out_valid/out_ready
//   returns one item per tick: charge_full and full_reason.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data);
//   write only while no tick is in flight.
// Path: an accepted tick waits in the input register, passes the check
//   logic and moves into the result register once that is free or draining.
// Throughput: one tick per cycle while out_ready stays high; the check stages
//   are a single pass of logic between the two registers.
// Reset: configuration registers return to their defaults (timeout 90 min,
//   4200 mV, pin present), debounce runs clear, slope ring goes all positive,
//   no voltage reference is held.
// Stall: a held result keeps its value; one more tick may wait in the input
//   register, then in_ready drops until out_ready returns.
// ----------------------------------------------------------------------------
module charge_termination_detector
#(
    parameter int SLOPE_SLOTS = ctd_pkg::SLOPE_SLOTS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [ctd_pkg::VOLT_W-1:0]  voltage_mv,
    input  logic [ctd_pkg::MIN_W-1:0]   elapsed_minutes,
    input  logic                        ext_pin_level,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        charge_full,
    output ctd_pkg::reason_t            full_reason,
    input  logic                        cfg_we,
    input  ctd_pkg::cfg_index_t         cfg_index,
    input  logic [ctd_pkg::CFG_W-1:0]   cfg_data
);

    ctd_pkg::cfg_t cfg;

    logic                       s1_valid_reg, s1_valid_next;
    logic [ctd_pkg::VOLT_W-1:0] s1_volt_reg;
    logic [ctd_pkg::MIN_W-1:0]  s1_min_reg;
    logic                       s1_pin_reg;
    logic                       out_valid_reg, out_valid_next;
    logic                       full_reg;
    ctd_pkg::reason_t           reason_reg;
    ctd_pkg::reason_t           reason;
    logic                       s1_move;
    logic                       in_take;

    ctd_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ctd_decide
    #(
        .SLOPE_SLOTS (SLOPE_SLOTS)
    )
    u_decide
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (s1_move),
        .voltage_mv      (s1_volt_reg),
        .elapsed_minutes (s1_min_reg),
        .ext_pin_level   (s1_pin_reg),
        .cfg             (cfg),
        .reason          (reason)
    );

    // the held item moves on whenever the result slot is free or draining
    assign s1_move  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_move;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next  = in_take || (s1_valid_reg && !s1_move);
        out_valid_next = s1_move || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_volt_reg <= voltage_mv;
            s1_min_reg  <= elapsed_minutes;
            s1_pin_reg  <= ext_pin_level;
        end
        if (s1_move)
        begin
            full_reg   <= reason != ctd_pkg::REASON_NONE;
            reason_reg <= reason;
        end
    end

    assign out_valid   = out_valid_reg;
    assign charge_full = full_reg;
    assign full_reason = reason_reg;

endmodule

/* hw/rtl/ctd_checker.sv */
// ----------------------------------------------------------------------------
// ctd_checker
// Port-level checks of the charge termination detector, bound to the top.
// ----------------------------------------------------------------------------
module ctd_checker
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic             charge_full,
    input ctd_pkg::reason_t full_reason
);

    // full flag and reason code agree
    a_full_matches_reason: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (charge_full == (full_reason != ctd_pkg::REASON_NONE)))
        else $error("charge_full disagrees with full_reason");

    a_reason_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (full_reason == ctd_pkg::REASON_NONE
                    || full_reason == ctd_pkg::REASON_TIMEOUT
                    || full_reason == ctd_pkg::REASON_OVERVOLT
                    || full_reason == ctd_pkg::REASON_PIN
                    || full_reason == ctd_pkg::REASON_SLOPE))
        else $error("full_reason out of range");

    // a result rising into an empty output slot comes from an accepted item via the input register
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without matching accepted item");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(charge_full)
                                    && $stable(full_reason))
        else $error("stalled result changed");

endmodule

bind charge_termination_detector ctd_checker u_ctd_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .charge_full (charge_full),
    .full_reason (full_reason)
);

/* tb/sv/charge_termination_detector_test.sv */
// ----------------------------------------------------------------------------
// charge_termination_detector_test
// Drives charging ticks through the detector with random gaps on both sides,
// predicts every verdict from a local copy of the debounce, phase and slope
// state, and compares each result item in order. Covers field extremes,
// charging sessions that reach every full reason, register sweeps, and a long
// receiver hold that backs the block up.
// ----------------------------------------------------------------------------
module charge_termination_detector_test;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 80;
    localparam int MAX_MV         = (1 << ctd_pkg::VOLT_W) - 1;
    localparam int MAX_MIN        = (1 << ctd_pkg::MIN_W) - 1;

    typedef enum int
    {
        SESS_CHARGE,
        SESS_PIN,
        SESS_OVERVOLT,
        SESS_NOISE
    } session_kind_t;

    typedef struct packed
    {
        logic             full;
        ctd_pkg::reason_t reason;
    } tick_verdict_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [ctd_pkg::VOLT_W-1:0] voltage_mv = '0;
    logic [ctd_pkg::MIN_W-1:0]  elapsed_minutes = '0;
    logic                       ext_pin_level = 1'b0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic                       charge_full;
    ctd_pkg::reason_t           full_reason;
    logic                       cfg_we = 1'b0;
    ctd_pkg::cfg_index_t        cfg_index = ctd_pkg::CFG_TIMEOUT;
    logic [ctd_pkg::CFG_W-1:0]  cfg_data = '0;

    // local copy of the configuration
    logic [ctd_pkg::MIN_W-1:0]  cfg_timeout = ctd_pkg::MIN_W'(ctd_pkg::TIMEOUT_RESET);
    logic [ctd_pkg::VOLT_W-1:0] cfg_full_mv = ctd_pkg::VOLT_W'(ctd_pkg::FULL_MV_RESET);
    logic                       cfg_pin_present = 1'b1;

    // local copy of the detector state
    int  model_phase = 0;
    int  ov_run = 0;
    int  pin_run = 0;
    int  ref_mv = 0;
    bit  slope_up [ctd_pkg::SLOPE_SLOTS_DEF] = '{default: 1'b1};
    int  slope_ptr = 0;

    tick_verdict_t verdict_q [$];

    bit  no_idle = 1'b0;
    int  ticks_sent = 0;
    int  error_count = 0;
    int  hold_asked = 0;
    int  hold_served = 0;
    int  hold_left = 0;
    int  stall_left = 0;
    int  quiet_cycles = 0;

    always #5 clk = ~clk;

    charge_termination_detector uut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .voltage_mv      (voltage_mv),
        .elapsed_minutes (elapsed_minutes),
        .ext_pin_level   (ext_pin_level),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .charge_full     (charge_full),
        .full_reason     (full_reason),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // tells whether the stage samples on this phase, then moves the phase on
    function automatic bit phase_sample(input int period);
        bit hit;
        hit = (model_phase % period) == 0;
        model_phase = (model_phase + 1) % ctd_pkg::PHASE_WRAP;
        return hit;
    endfunction

    function automatic tick_verdict_t judge_tick(input logic [ctd_pkg::VOLT_W-1:0] mv,
                                                 input logic [ctd_pkg::MIN_W-1:0] minutes,
                                                 input logic pin);
        ctd_pkg::reason_t why;
        int               ups;
        tick_verdict_t    verdict;
        why = ctd_pkg::REASON_NONE;
        if (minutes >= cfg_timeout)
            why = ctd_pkg::REASON_TIMEOUT;
        else
        begin
            if (phase_sample(ctd_pkg::OV_MEASURE))
            begin
                if (int'(mv) >= int'(cfg_full_mv) + ctd_pkg::CHARGE_OFFSET_MV)
                begin
                    if (ov_run < ctd_pkg::OV_RUN_MAX)
                        ov_run++;
                end
                else
                    ov_run = 0;
                if (ov_run >= ctd_pkg::OV_DEBOUNCE)
                    why = ctd_pkg::REASON_OVERVOLT;
            end
            if (why == ctd_pkg::REASON_NONE)
            begin
                // phase moves on even when the pin is not wired
                if (phase_sample(ctd_pkg::PIN_MEASURE) && cfg_pin_present)
                begin
                    if (pin)
                    begin
                        if (pin_run < ctd_pkg::PIN_RUN_MAX)
                            pin_run++;
                    end
                    else
                        pin_run = 0;
                    if (pin_run >= ctd_pkg::PIN_DEBOUNCE)
                        why = ctd_pkg::REASON_PIN;
                end
            end
            if (why == ctd_pkg::REASON_NONE)
            begin
                if (phase_sample(ctd_pkg::SLOPE_MEASURE))
                begin
                    if (ref_mv == 0)
                    begin
                        foreach (slope_up[k])
                            slope_up[k] = 1'b1;
                        ref_mv = int'(mv);
                    end
                    else
                    begin
                        slope_up[slope_ptr] = int'(mv) > ref_mv;
                        ref_mv = int'(mv);
                        ups = 0;
                        foreach (slope_up[k])
                            ups += slope_up[k];
                        // score is rising slots minus the rest, compared signed
                        if (2 * ups - ctd_pkg::SLOPE_SLOTS_DEF <= 1 &&
                            int'(mv) >= int'(cfg_full_mv) - ctd_pkg::CHARGE_OFFSET_MV)
                            why = ctd_pkg::REASON_SLOPE;
                    end
                    slope_ptr = (slope_ptr + 1) % ctd_pkg::SLOPE_SLOTS_DEF;
                end
            end
        end
        verdict.full = (why != ctd_pkg::REASON_NONE);
        verdict.reason = why;
        return verdict;
    endfunction

    function automatic logic [ctd_pkg::VOLT_W-1:0] clamp_mv(input int x);
        if (x < 0)
            return '0;
        if (x > MAX_MV)
            return ctd_pkg::VOLT_W'(MAX_MV);
        return ctd_pkg::VOLT_W'(x);
    endfunction

    function automatic logic [ctd_pkg::MIN_W-1:0] pick_elapsed();
        if (cfg_timeout == 0 || $urandom_range(0, 15) == 0)
            return ctd_pkg::MIN_W'($urandom_range(0, MAX_MIN));
        return ctd_pkg::MIN_W'($urandom_range(0, int'(cfg_timeout) - 1));
    endfunction

    // called just after a rising edge; returns just after the accepting edge
    task automatic send_tick(input logic [ctd_pkg::VOLT_W-1:0] mv,
                             input logic [ctd_pkg::MIN_W-1:0] minutes,
                             input logic pin);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        voltage_mv <= mv;
        elapsed_minutes <= minutes;
        ext_pin_level <= pin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        verdict_q.push_back(judge_tick(mv, minutes, pin));
        ticks_sent++;
    endtask

    task automatic drain_ticks();
        in_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_config(input int timeout, input int full_mv, input bit pin_present);
        drain_ticks();
        cfg_we <= 1'b1;
        // bits above a register's width are don't care
        cfg_index <= ctd_pkg::CFG_TIMEOUT;
        cfg_data <= {3'($urandom_range(0, 7)), ctd_pkg::MIN_W'(timeout)};
        @(posedge clk);
        cfg_index <= ctd_pkg::CFG_FULL_MV;
        cfg_data <= ctd_pkg::VOLT_W'(full_mv);
        @(posedge clk);
        cfg_index <= ctd_pkg::CFG_PIN_PRES;
        cfg_data <= {12'($urandom_range(0, 4095)), pin_present};
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_timeout = ctd_pkg::MIN_W'(timeout);
        cfg_full_mv = ctd_pkg::VOLT_W'(full_mv);
        cfg_pin_present = pin_present;
    endtask

    task automatic run_session(input session_kind_t kind, input int len);
        int full;
        int mv;
        full = int'(cfg_full_mv);
        mv = full - int'($urandom_range(20, 120));
        for (int i = 0; i < len; i++)
        begin
            case (kind)
                SESS_CHARGE:
                begin
                    // climb toward full, then sit on a noisy plateau around it
                    if (i < len / 3)
                        mv += int'($urandom_range(0, 6)) - 1;
                    else
                    begin
                        mv += int'($urandom_range(0, 4)) - 2;
                        if (mv > full + 15)
                            mv = full + 15;
                        if (mv < full - 30)
                            mv = full - 30;
                    end
                    send_tick(clamp_mv(mv), pick_elapsed(), $urandom_range(0, 9) == 0);
                end
                SESS_PIN:
                    send_tick(clamp_mv(full - int'($urandom_range(40, 500))), pick_elapsed(),
                              $urandom_range(0, 15) != 0);
                SESS_OVERVOLT:
                begin
                    if ($urandom_range(0, 7) == 0)
                        mv = full - int'($urandom_range(0, 300));
                    else
                        mv = full + int'($urandom_range(20, 200));
                    send_tick(clamp_mv(mv), pick_elapsed(), 1'($urandom_range(0, 1)));
                end
                default:
                    send_tick(ctd_pkg::VOLT_W'($urandom_range(0, MAX_MV)),
                              ctd_pkg::MIN_W'($urandom_range(0, MAX_MIN)),
                              1'($urandom_range(0, 1)));
            endcase
        end
    endtask

    task automatic run_random(input int items);
        int            stop_at;
        int            pick;
        int            len;
        session_kind_t kind;
        stop_at = ticks_sent + items;
        while (ticks_sent < stop_at)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
            begin
                kind = SESS_CHARGE;
                len = $urandom_range(100, 200);
            end
            else if (pick < 6)
            begin
                kind = SESS_PIN;
                len = $urandom_range(50, 90);
            end
            else if (pick < 8)
            begin
                kind = SESS_OVERVOLT;
                len = $urandom_range(20, 50);
            end
            else
            begin
                kind = SESS_NOISE;
                len = $urandom_range(5, 20);
            end
            // the last session is cut short at the item budget
            if (len > stop_at - ticks_sent)
                len = stop_at - ticks_sent;
            run_session(kind, len);
        end
    endtask

    task automatic test_field_extremes();
        send_tick(0, 0, 1'b0);
        send_tick(8191, 0, 1'b1);
        send_tick(4220, 0, 1'b1);
        send_tick(4219, 89, 1'b1);
        send_tick(4200, 90, 1'b0);
        send_tick(0, 1023, 1'b1);
        send_tick(13'h1555, 10'h2aa, 1'b0);
        send_tick(13'h0aaa, 10'h155, 1'b1);
        // zero timeout: every tick times out
        apply_config(0, 4200, 1'b1);
        send_tick(0, 0, 1'b0);
        send_tick(8191, 1023, 1'b1);
        // zero full voltage, pin not wired
        apply_config(1023, 0, 1'b0);
        send_tick(8191, 1022, 1'b1);
        send_tick(0, 1023, 1'b0);
        send_tick(20, 0, 1'b1);
        send_tick(19, 1, 1'b0);
        send_tick(1, 2, 1'b1);
        apply_config(1023, 8191, 1'b1);
        send_tick(8191, 0, 1'b1);
        send_tick(8190, 5, 1'b1);
        send_tick(4096, 512, 1'b0);
    endtask

    task automatic test_charge_profiles();
        apply_config(ctd_pkg::TIMEOUT_RESET, ctd_pkg::FULL_MV_RESET,
                     1'(ctd_pkg::PIN_PRES_RESET));
        run_random(200);
    endtask

    task automatic test_back_to_back();
        apply_config(600, 4000, 1'b1);
        no_idle = 1'b1;
        run_random(80);
        no_idle = 1'b0;
    endtask

    task automatic test_receiver_hold();
        apply_config(900, 3700, 1'b1);
        no_idle = 1'b1;
        hold_asked++;
        run_session(SESS_CHARGE, 40);
        no_idle = 1'b0;
    endtask

    task automatic test_config_sweep();
        apply_config(1023, 0, 1'b0);
        run_random(40);
        apply_config(1023, 8191, 1'b1);
        run_random(40);
        apply_config($urandom_range(200, 1023), $urandom_range(3000, 5000),
                     1'($urandom_range(0, 1)));
        run_random(40);
        apply_config($urandom_range(0, 1023), $urandom_range(0, 8191), 1'b1);
        run_random(40);
    endtask

    // result side: random stalls per item, plus one long hold on request
    always @(posedge clk)
    begin
        tick_verdict_t want;
        logic ready_next;
        if (out_valid && out_ready)
        begin
            if (verdict_q.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result item: full=%0d reason=%0d",
                             charge_full, full_reason);
            end
            else
            begin
                want = verdict_q.pop_front();
                if (charge_full !== want.full || full_reason !== want.reason)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("mismatch: expected full=%0d reason=%0d got full=%0d reason=%0d",
                                 want.full, want.reason, charge_full, full_reason);
                end
            end
            stall_left = no_idle ? 0 : $urandom_range(0, 7);
        end
        if (hold_asked != hold_served)
        begin
            hold_served = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            ready_next = 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            ready_next = 1'b0;
        end
        else
            ready_next = 1'b1;
        out_ready <= ready_next;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("charge_termination_detector_test failed");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_field_extremes();
        test_charge_profiles();
        test_back_to_back();
        test_receiver_hold();
        test_config_sweep();
        drain_ticks();
        if (error_count == 0 && verdict_q.size() == 0)
            $display("charge_termination_detector_test passed");
        else
            $display("charge_termination_detector_test failed");
        $finish;
    end

endmodule

/* charge_termination_detector.f */
hw/rtl/ctd_pkg.sv
hw/rtl/ctd_cfg_regs.sv
hw/rtl/ctd_decide.sv
hw/rtl/charge_termination_detector.sv
hw/rtl/ctd_checker.sv
tb/sv/charge_termination_detector_test.sv
